// File: rtl/arbb_pkg.sv
// Shared types, register codes and clip helpers for the affine rectangle bounding box unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package arbb_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned PROD_W = 2 * DATA_W - FRAC_W;   // product with fraction dropped
    localparam int unsigned SUM_W  = PROD_W + 1;            // sum of two products
    localparam int unsigned ORG_W  = SUM_W + 1;             // plus translation, or span
    localparam int unsigned SIZE_W = DATA_W - 1;
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_COEF_XX = 3'd0;
    localparam logic [2:0] REG_COEF_XY = 3'd1;
    localparam logic [2:0] REG_COEF_YX = 3'd2;
    localparam logic [2:0] REG_COEF_YY = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;

    localparam logic signed [DATA_W-1:0] RST_COEF_ONE  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_COEF_ZERO = 32'sd0;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_xx;
        logic signed [DATA_W-1:0] coef_xy;
        logic signed [DATA_W-1:0] coef_yx;
        logic signed [DATA_W-1:0] coef_yy;
        logic signed [DATA_W-1:0] shift_x;
        logic signed [DATA_W-1:0] shift_y;
    } t_cfg;

    // normalized rectangle edges
    typedef struct packed {
        logic signed [DATA_W-1:0] lo_x;
        logic signed [DATA_W-1:0] hi_x;
        logic signed [DATA_W-1:0] lo_y;
        logic signed [DATA_W-1:0] hi_y;
        logic                     sat;
    } t_edge;

    // per-axis extremes of the truncated products
    typedef struct packed {
        logic signed [PROD_W-1:0] min_px;  // x term of output x
        logic signed [PROD_W-1:0] max_px;
        logic signed [PROD_W-1:0] min_py;  // y term of output x
        logic signed [PROD_W-1:0] max_py;
        logic signed [PROD_W-1:0] min_qx;  // x term of output y
        logic signed [PROD_W-1:0] max_qx;
        logic signed [PROD_W-1:0] min_qy;  // y term of output y
        logic signed [PROD_W-1:0] max_qy;
        logic                     sat;
    } t_ext;

    function automatic logic signed [DATA_W-1:0] clip33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic ovf33(input logic signed [DATA_W:0] v);
        return v[DATA_W] != v[DATA_W-1];
    endfunction

endpackage

`default_nettype wire

// File: rtl/arbb_cfg.sv
// APB register file holding the transform coefficients and translation.
// Depends on arbb_pkg for the register codes and the t_cfg type.
`default_nettype none

module arbb_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [arbb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [arbb_pkg::DATA_W-1:0]  pwdata,
    output logic      [arbb_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output arbb_pkg::t_cfg                    o_cfg
);
    import arbb_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_xx <= RST_COEF_ONE;
            r_cfg.coef_xy <= RST_COEF_ZERO;
            r_cfg.coef_yx <= RST_COEF_ZERO;
            r_cfg.coef_yy <= RST_COEF_ONE;
            r_cfg.shift_x <= RST_COEF_ZERO;
            r_cfg.shift_y <= RST_COEF_ZERO;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COEF_XX: r_cfg.coef_xx <= pwdata;
                REG_COEF_XY: r_cfg.coef_xy <= pwdata;
                REG_COEF_YX: r_cfg.coef_yx <= pwdata;
                REG_COEF_YY: r_cfg.coef_yy <= pwdata;
                REG_SHIFT_X: r_cfg.shift_x <= pwdata;
                REG_SHIFT_Y: r_cfg.shift_y <= pwdata;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COEF_XX: prdata = r_cfg.coef_xx;
            REG_COEF_XY: prdata = r_cfg.coef_xy;
            REG_COEF_YX: prdata = r_cfg.coef_yx;
            REG_COEF_YY: prdata = r_cfg.coef_yy;
            REG_SHIFT_X: prdata = r_cfg.shift_x;
            REG_SHIFT_Y: prdata = r_cfg.shift_y;
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/arbb_edge.sv
// Stage 1: normalize origin plus extent to low and high edges, clipped to 32 bits.
// Depends on arbb_pkg for t_edge and the clip helpers.
`default_nettype none

module arbb_edge (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [arbb_pkg::DATA_W-1:0]  i_rect_x,
    input  wire logic signed [arbb_pkg::DATA_W-1:0]  i_rect_y,
    input  wire logic signed [arbb_pkg::DATA_W-1:0]  i_rect_width,
    input  wire logic signed [arbb_pkg::DATA_W-1:0]  i_rect_height,
    output logic                                     o_valid,
    output arbb_pkg::t_edge                          o_edge
);
    import arbb_pkg::*;

    logic                   r_valid;
    t_edge                  r_edge;
    t_edge                  n_edge;
    logic signed [DATA_W:0] ox, oy, fx, fy, lx, hx, ly, hy;

    always_comb begin
        ox = {i_rect_x[DATA_W-1], i_rect_x};
        oy = {i_rect_y[DATA_W-1], i_rect_y};
        fx = ox + {i_rect_width[DATA_W-1], i_rect_width};
        fy = oy + {i_rect_height[DATA_W-1], i_rect_height};
        lx = (ox < fx) ? ox : fx;
        hx = (ox < fx) ? fx : ox;
        ly = (oy < fy) ? oy : fy;
        hy = (oy < fy) ? fy : oy;
        n_edge.lo_x = clip33(lx);
        n_edge.hi_x = clip33(hx);
        n_edge.lo_y = clip33(ly);
        n_edge.hi_y = clip33(hy);
        n_edge.sat  = ovf33(lx) | ovf33(hx) | ovf33(ly) | ovf33(hy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_edge <= n_edge;
        end
    end

    assign o_valid = r_valid;
    assign o_edge  = r_edge;

endmodule

`default_nettype wire

// File: rtl/arbb_xform.sv
// Stages 2 and 3: eight 32x32 products truncated to Q16.16, then per-term min and max.
// Depends on arbb_pkg for t_cfg, t_edge and t_ext.
`default_nettype none

module arbb_xform (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire arbb_pkg::t_edge i_edge,
    input  wire arbb_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    output arbb_pkg::t_ext       o_ext
);
    import arbb_pkg::*;

    localparam int unsigned NPROD = 8;

    logic                       r_valid2, r_valid3;
    logic                       r_sat2;
    logic signed [PROD_W-1:0]   r_prod [NPROD];
    logic signed [2*DATA_W-1:0] n_prod [NPROD];
    t_ext                       r_ext;
    t_ext                       n_ext;

    // product order: px lo/hi, py lo/hi, qx lo/hi, qy lo/hi
    always_comb begin
        n_prod[0] = i_edge.lo_x * i_cfg.coef_xx;
        n_prod[1] = i_edge.hi_x * i_cfg.coef_xx;
        n_prod[2] = i_edge.lo_y * i_cfg.coef_yx;
        n_prod[3] = i_edge.hi_y * i_cfg.coef_yx;
        n_prod[4] = i_edge.lo_x * i_cfg.coef_xy;
        n_prod[5] = i_edge.hi_x * i_cfg.coef_xy;
        n_prod[6] = i_edge.lo_y * i_cfg.coef_yy;
        n_prod[7] = i_edge.hi_y * i_cfg.coef_yy;
    end

    // a negative coefficient swaps which edge gives the smaller term
    always_comb begin
        n_ext.min_px = (r_prod[0] < r_prod[1]) ? r_prod[0] : r_prod[1];
        n_ext.max_px = (r_prod[0] < r_prod[1]) ? r_prod[1] : r_prod[0];
        n_ext.min_py = (r_prod[2] < r_prod[3]) ? r_prod[2] : r_prod[3];
        n_ext.max_py = (r_prod[2] < r_prod[3]) ? r_prod[3] : r_prod[2];
        n_ext.min_qx = (r_prod[4] < r_prod[5]) ? r_prod[4] : r_prod[5];
        n_ext.max_qx = (r_prod[4] < r_prod[5]) ? r_prod[5] : r_prod[4];
        n_ext.min_qy = (r_prod[6] < r_prod[7]) ? r_prod[6] : r_prod[7];
        n_ext.max_qy = (r_prod[6] < r_prod[7]) ? r_prod[7] : r_prod[6];
        n_ext.sat    = r_sat2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    // drop the 16 fraction bits: arithmetic truncation floors toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NPROD; k++) begin
                r_prod[k] <= n_prod[k][2*DATA_W-1:FRAC_W];
            end
            r_sat2 <= i_edge.sat;
            r_ext  <= n_ext;
        end
    end

    assign o_valid = r_valid3;
    assign o_ext   = r_ext;

endmodule

`default_nettype wire

// File: rtl/arbb_reduce.sv
// Stages 4 to 6: sum the term extremes, add translation, form spans, clip into the output register.
// Depends on arbb_pkg for t_cfg and t_ext.
`default_nettype none

module arbb_reduce (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire arbb_pkg::t_ext                     i_ext,
    input  wire arbb_pkg::t_cfg                     i_cfg,
    output logic                                    o_valid,
    output logic signed [arbb_pkg::DATA_W-1:0]      o_box_x,
    output logic signed [arbb_pkg::DATA_W-1:0]      o_box_y,
    output logic        [arbb_pkg::SIZE_W-1:0]      o_box_width,
    output logic        [arbb_pkg::SIZE_W-1:0]      o_box_height,
    output logic                                    o_saturated
);
    import arbb_pkg::*;

    localparam int unsigned HI_W = ORG_W - DATA_W + 1;  // bits that must agree with the sign

    logic                    r_valid4, r_valid5, r_valid6;
    logic signed [SUM_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                    r_sat4, r_sat5;
    logic signed [ORG_W-1:0] r_org_x, r_org_y, r_span_x, r_span_y;
    logic signed [DATA_W-1:0] r_box_x, r_box_y, n_box_x, n_box_y;
    logic        [SIZE_W-1:0] r_box_w, r_box_h, n_box_w, n_box_h;
    logic                     r_sat6, n_sat;
    logic                     ovf_x, ovf_y, ovf_w, ovf_h;

    always_comb begin
        ovf_x = r_org_x[ORG_W-1:DATA_W-1] != {HI_W{r_org_x[ORG_W-1]}};
        ovf_y = r_org_y[ORG_W-1:DATA_W-1] != {HI_W{r_org_y[ORG_W-1]}};
        ovf_w = |r_span_x[ORG_W-1:SIZE_W];
        ovf_h = |r_span_y[ORG_W-1:SIZE_W];
        if (ovf_x) begin
            n_box_x = r_org_x[ORG_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_box_x = r_org_x[DATA_W-1:0];
        end
        if (ovf_y) begin
            n_box_y = r_org_y[ORG_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_box_y = r_org_y[DATA_W-1:0];
        end
        n_box_w = ovf_w ? {SIZE_W{1'b1}} : r_span_x[SIZE_W-1:0];
        n_box_h = ovf_h ? {SIZE_W{1'b1}} : r_span_y[SIZE_W-1:0];
        n_sat   = r_sat5 | ovf_x | ovf_y | ovf_w | ovf_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
            r_valid6 <= 1'b0;
        end else if (i_en) begin
            r_valid4 <= i_valid;
            r_valid5 <= r_valid4;
            r_valid6 <= r_valid5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 4: the box extremes split into independent x and y terms
            r_min_x  <= SUM_W'(i_ext.min_px) + SUM_W'(i_ext.min_py);
            r_max_x  <= SUM_W'(i_ext.max_px) + SUM_W'(i_ext.max_py);
            r_min_y  <= SUM_W'(i_ext.min_qx) + SUM_W'(i_ext.min_qy);
            r_max_y  <= SUM_W'(i_ext.max_qx) + SUM_W'(i_ext.max_qy);
            r_sat4   <= i_ext.sat;
            // stage 5
            r_org_x  <= ORG_W'(r_min_x) + ORG_W'(i_cfg.shift_x);
            r_org_y  <= ORG_W'(r_min_y) + ORG_W'(i_cfg.shift_y);
            r_span_x <= ORG_W'(r_max_x) - ORG_W'(r_min_x);
            r_span_y <= ORG_W'(r_max_y) - ORG_W'(r_min_y);
            r_sat5   <= r_sat4;
            // stage 6: output register
            r_box_x  <= n_box_x;
            r_box_y  <= n_box_y;
            r_box_w  <= n_box_w;
            r_box_h  <= n_box_h;
            r_sat6   <= n_sat;
        end
    end

    assign o_valid      = r_valid6;
    assign o_box_x      = r_box_x;
    assign o_box_y      = r_box_y;
    assign o_box_width  = r_box_w;
    assign o_box_height = r_box_h;
    assign o_saturated  = r_sat6;

endmodule

`default_nettype wire

// File: rtl/affine_rect_bounding_box_unit.sv
// Top level of the affine rectangle bounding box unit: stream ports, APB registers, pipeline.
// Depends on arbb_pkg, arbb_cfg, arbb_edge, arbb_xform and arbb_reduce.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid / tready         rectangle x, y, width, height
//   m_axis    out        tvalid / tready         box x, y, width, height; tuser saturated
//   apb       in         psel / penable / pready transform registers, 5-bit byte address
//
// Six register stages: edges, products, min/max, sums, translation and span, clip.
// One rectangle is taken every clock while m_axis does not stall; the eight parallel
// 32x32 multipliers of stage 2 set the clock.
// Reset clears the valid bits and loads the identity transform.
// A stall on m_axis freezes every stage together, so s_axis tready falls in the same cycle.
`default_nettype none

module affine_rect_bounding_box_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // rect_x [31:0], rect_y [63:32], rect_width [95:64], rect_height [127:96]
    input  wire logic [127:0]                  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // box_x [31:0], box_y [63:32], box_width [94:64], box_height [125:95], zero [127:126]
    output logic [127:0]                       o_m_axis_tdata,
    // saturated [0]
    output logic [0:0]                         o_m_axis_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [arbb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [arbb_pkg::DATA_W-1:0]   pwdata,
    output logic      [arbb_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import arbb_pkg::*;

    t_cfg                     cfg;
    t_edge                    edge_q;
    t_ext                     ext_q;
    logic                     en;
    logic                     edge_valid, ext_valid;
    logic signed [DATA_W-1:0] box_x, box_y;
    logic        [SIZE_W-1:0] box_w, box_h;
    logic                     sat;

    // advance whenever the output register is empty or being taken
    assign en              = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = en;

    arbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    arbb_edge u_edge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_s_axis_tvalid),
        .i_rect_x      (i_s_axis_tdata[31:0]),
        .i_rect_y      (i_s_axis_tdata[63:32]),
        .i_rect_width  (i_s_axis_tdata[95:64]),
        .i_rect_height (i_s_axis_tdata[127:96]),
        .o_valid       (edge_valid),
        .o_edge        (edge_q)
    );

    arbb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (edge_valid),
        .i_edge  (edge_q),
        .i_cfg   (cfg),
        .o_valid (ext_valid),
        .o_ext   (ext_q)
    );

    arbb_reduce u_reduce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (ext_valid),
        .i_ext        (ext_q),
        .i_cfg        (cfg),
        .o_valid      (o_m_axis_tvalid),
        .o_box_x      (box_x),
        .o_box_y      (box_y),
        .o_box_width  (box_w),
        .o_box_height (box_h),
        .o_saturated  (sat)
    );

    assign o_m_axis_tdata = {2'b00, box_h, box_w, box_y, box_x};
    assign o_m_axis_tuser = sat;

endmodule

`default_nettype wire
